// ===== src/calda_pkg.sv =====
package calda_pkg;

    // Request codes carried on the input tuser
    localparam logic [2:0] REQ_VALIDATE = 3'd0;
    localparam logic [2:0] REQ_DAYS     = 3'd1;
    localparam logic [2:0] REQ_DOY      = 3'd2;
    localparam logic [2:0] REQ_REVERSE  = 3'd3;
    localparam logic [2:0] REQ_RANGE    = 3'd4;

    localparam int unsigned IN_DATA_W  = 64;
    localparam int unsigned OUT_DATA_W = 56;
    localparam int unsigned DAYS_W     = 25;   // days since the start of year 0
    localparam int unsigned SECS_W     = 41;

    localparam logic [3:0]  LAST_MONTH  = 4'd12;
    localparam logic [3:0]  FEB         = 4'd2;
    localparam logic [16:0] SEC_PER_DAY = 17'd86400;

    // floor(2^24 / 100): reciprocal for dividing a year by 100
    localparam logic [17:0] RECIP_100   = 18'd167772;
    localparam int unsigned RECIP_SHIFT = 24;

    // Month lengths in a common year, indexed by month; codes 0 and 13..15 read 0
    localparam logic [4:0] MONTH_LEN [16] = '{
        5'd0,  5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0,  5'd0,  5'd0
    };

    // Days before the first of each month in a common year
    localparam logic [8:0] CUM_DAYS [16] = '{
        9'd0,   9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd0,   9'd0,   9'd0
    };

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture a new request
        logic ysel;       // year unit works on year_b
        logic y_mul;      // multiply year by the reciprocal
        logic y_fix;      // correct the quotient, flag whole centuries
        logic y_save;     // store leap flag and days before the year
        logic walk_step;  // advance the month walk
        logic pos;        // form day positions of both dates
        logic absd;       // absolute day difference
        logic scale;      // days to seconds
        logic out_load;   // load the result word
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [2:0] req;
        logic       walk_done;
    } dp_sts_t;

    function automatic logic month_valid(input logic [3:0] m);
        return (m != 4'd0) && (m <= LAST_MONTH);
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        return MONTH_LEN[m] + {4'd0, (m == FEB) && leap};
    endfunction

    function automatic logic [8:0] day_in_year(input logic [3:0] m, input logic leap,
                                               input logic [4:0] d);
        return CUM_DAYS[m] + {8'd0, (m > FEB) && leap} + {4'd0, d};
    endfunction

endpackage

// ===== src/calendar_date_arithmetic.sv =====
// Channel | Direction | Handshake              | Payload
// s_axis  | in        | s_axis_tvalid / tready | tuser: req_type; tdata: both dates, day_of_year
// m_axis  | out       | m_axis_tvalid / tready | tdata: status, date_ok, value, month, day
//
// One request at a time. Validate, days-in-month and day-of-year run the divide-by-100
// year unit (multiply, correct, save), then load the result.
// Reverse day of year then steps through the months, walking 1 to 12 of them;
// range runs the year unit twice, then position, difference and seconds.
// Input is ready again the cycle after the load; a waiting result holds the load.
// Reset is synchronous; the output register holds a result until m_axis_tready.
module calendar_date_arithmetic
    import calda_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [2:0]            s_axis_tuser,   // [2:0] req_type
    // [15:0] year_a, [19:16] month_a, [24:20] day_a, [33:25] day_of_year,
    // [49:34] year_b, [53:50] month_b, [58:54] day_b, [63:59] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] status, [1] date_ok, [42:2] result_value, [46:43] out_month,
    // [55:47] out_day
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    calda_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    calda_dp u_dp (
        .aclk     (aclk),
        .cmd      (cmd),
        .in_req   (s_axis_tuser),
        .in_data  (s_axis_tdata),
        .sts      (sts),
        .out_data (m_axis_tdata)
    );

endmodule

// ===== src/calda_ctrl.sv =====
module calda_ctrl
    import calda_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_YMUL  = 9'b000000010,
        ST_YFIX  = 9'b000000100,
        ST_YSAVE = 9'b000001000,
        ST_WALK  = 9'b000010000,
        ST_POS   = 9'b000100000,
        ST_ABS   = 9'b001000000,
        ST_SCALE = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   ysel_reg, ysel_next;
    logic   m_valid_reg, m_valid_next;

    // Sequence one request through the datapath
    always_comb begin
        state_next = state_reg;
        ysel_next  = ysel_reg;
        cmd        = '0;
        cmd.ysel   = ysel_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    ysel_next  = 1'b0;
                    state_next = ST_YMUL;
                end
            end
            ST_YMUL: begin
                cmd.y_mul  = 1'b1;
                state_next = ST_YFIX;
            end
            ST_YFIX: begin
                cmd.y_fix  = 1'b1;
                state_next = ST_YSAVE;
            end
            ST_YSAVE: begin
                cmd.y_save = 1'b1;
                priority if (sts.req == REQ_RANGE && !ysel_reg) begin
                    ysel_next  = 1'b1;
                    state_next = ST_YMUL;
                end else if (sts.req == REQ_RANGE) begin
                    state_next = ST_POS;
                end else if (sts.req == REQ_REVERSE) begin
                    state_next = ST_WALK;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_WALK: begin
                cmd.walk_step = 1'b1;
                if (sts.walk_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_POS: begin
                cmd.pos    = 1'b1;
                state_next = ST_ABS;
            end
            ST_ABS: begin
                cmd.absd   = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // Hand over once the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output valid: set on load, drop when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ysel_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ysel_reg    <= ysel_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// ===== src/calda_dp.sv =====
module calda_dp
    import calda_pkg::*;
(
    input  logic                  aclk,
    input  dp_cmd_t               cmd,
    input  logic [2:0]            in_req,
    input  logic [IN_DATA_W-1:0]  in_data,
    output dp_sts_t               sts,
    output logic [OUT_DATA_W-1:0] out_data
);

    // Captured request
    logic [2:0]  req_reg;
    logic [15:0] ya_reg, yb_reg;
    logic [3:0]  ma_reg, mb_reg;
    logic [4:0]  da_reg, db_reg;

    // Year unit
    logic [33:0] prod_reg, prod_next;
    logic [9:0]  q_reg, q_next;
    logic        hz_reg, hz_next;
    logic        leap_a_reg, leap_b_reg, leap_next;
    logic [DAYS_W-1:0] dbef_a_reg, dbef_b_reg, dbef_next;

    // Month walk
    logic [3:0] wm_reg, wm_next;
    logic [8:0] rem_reg, rem_next;

    // Range path
    logic [DAYS_W-1:0] pos_a_reg, pos_b_reg, pos_a_next, pos_b_next;
    logic [DAYS_W-1:0] diff_reg, diff_next;
    logic [SECS_W-1:0] sec_reg, sec_next;
    logic [41:0]       sec_full;

    logic [OUT_DATA_W-1:0] out_reg, out_next;

    logic [15:0] y_sel;
    logic [9:0]  q0;
    logic [16:0] rem100;
    logic [9:0]  cent;
    logic [4:0]  dim_w;
    logic        walk_done;

    // Year unit: divide by 100, leap rule, days before the year
    always_comb begin
        y_sel     = cmd.ysel ? yb_reg : ya_reg;
        prod_next = 34'(y_sel) * 34'(RECIP_100);
        q0        = prod_reg[RECIP_SHIFT+9:RECIP_SHIFT];
        rem100    = {1'b0, y_sel} - 17'(q0) * 17'd100;
        q_next    = q0 + {9'd0, rem100 >= 17'd100};
        hz_next   = (rem100 == 17'd0) || (rem100 == 17'd100);
        leap_next = ((y_sel[1:0] == 2'd0) && !hz_reg) || (hz_reg && (q_reg[1:0] == 2'd0));
        cent      = q_reg + {9'd0, !hz_reg};
        dbef_next = DAYS_W'(y_sel) * DAYS_W'(365)
                  + DAYS_W'(({1'b0, y_sel} + 17'd3) >> 2)
                  - DAYS_W'(cent)
                  + DAYS_W'(({1'b0, cent} + 11'd3) >> 2);
    end

    // Month walk for the reverse conversion
    always_comb begin
        dim_w     = month_days(wm_reg, leap_a_reg);
        walk_done = (wm_reg == LAST_MONTH) || ({4'd0, dim_w} >= rem_reg);
        wm_next   = wm_reg;
        rem_next  = rem_reg;
        if (cmd.load) begin
            wm_next  = 4'd1;
            rem_next = in_data[33:25];
        end else if (cmd.walk_step && !walk_done) begin
            wm_next  = wm_reg + 4'd1;
            rem_next = rem_reg - {4'd0, dim_w};
        end
    end

    // Day positions, distance and seconds
    always_comb begin
        pos_a_next = dbef_a_reg + DAYS_W'(day_in_year(ma_reg, leap_a_reg, da_reg));
        pos_b_next = dbef_b_reg + DAYS_W'(day_in_year(mb_reg, leap_b_reg, db_reg));
        diff_next  = (pos_b_reg >= pos_a_reg) ? (pos_b_reg - pos_a_reg)
                                              : (pos_a_reg - pos_b_reg);
        sec_full   = 42'(diff_reg) * 42'(SEC_PER_DAY);
        sec_next   = sec_full[SECS_W-1:0];
    end

    // Assemble the result word
    always_comb begin
        logic             st;
        logic             ok;
        logic [SECS_W-1:0] val;
        logic [3:0]       om;
        logic [8:0]       od;
        st  = 1'b0;
        ok  = 1'b0;
        val = '0;
        om  = '0;
        od  = '0;
        unique case (req_reg)
            REQ_VALIDATE: begin
                ok = (ya_reg != 16'd0) && month_valid(ma_reg) && (da_reg != 5'd0)
                  && (da_reg <= month_days(ma_reg, leap_a_reg));
            end
            REQ_DAYS: begin
                if (month_valid(ma_reg)) begin
                    val = SECS_W'(month_days(ma_reg, leap_a_reg));
                end else begin
                    st = 1'b1;
                end
            end
            REQ_DOY: begin
                if (month_valid(ma_reg)) begin
                    val = SECS_W'(day_in_year(ma_reg, leap_a_reg, da_reg));
                end else begin
                    st = 1'b1;
                end
            end
            REQ_REVERSE: begin
                om = wm_reg;
                od = rem_reg;
            end
            REQ_RANGE: begin
                if (month_valid(ma_reg) && month_valid(mb_reg)) begin
                    val = sec_reg;
                end else begin
                    st = 1'b1;
                end
            end
            default: ;
        endcase
        out_next = {od, om, val, ok, st};
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= in_req;
            ya_reg  <= in_data[15:0];
            ma_reg  <= in_data[19:16];
            da_reg  <= in_data[24:20];
            yb_reg  <= in_data[49:34];
            mb_reg  <= in_data[53:50];
            db_reg  <= in_data[58:54];
        end
        wm_reg  <= wm_next;
        rem_reg <= rem_next;
        if (cmd.y_mul) begin
            prod_reg <= prod_next;
        end
        if (cmd.y_fix) begin
            q_reg  <= q_next;
            hz_reg <= hz_next;
        end
        if (cmd.y_save && !cmd.ysel) begin
            leap_a_reg <= leap_next;
            dbef_a_reg <= dbef_next;
        end
        if (cmd.y_save && cmd.ysel) begin
            leap_b_reg <= leap_next;
            dbef_b_reg <= dbef_next;
        end
        if (cmd.pos) begin
            pos_a_reg <= pos_a_next;
            pos_b_reg <= pos_b_next;
        end
        if (cmd.absd) begin
            diff_reg <= diff_next;
        end
        if (cmd.scale) begin
            sec_reg <= sec_next;
        end
        if (cmd.out_load) begin
            out_reg <= out_next;
        end
    end

    assign sts.req       = req_reg;
    assign sts.walk_done = walk_done;
    assign out_data      = out_reg;

endmodule
